// ===== design/frm_pkg.sv =====
// Shared types, constants and codes of the frame readout manager.
package frm_pkg;

  localparam int FRAME_FIFO_DEPTH = 8;
  localparam int ORBIT_LENGTH     = 3564;
  localparam int EVENT_BUFFERS    = 3;

  localparam int FILL_W  = $clog2(FRAME_FIFO_DEPTH + 1);
  localparam int BUNCH_W = 12;
  localparam int EVC_W   = 2;
  localparam int CFG_W   = 4;
  localparam int IDX_W   = 2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] CFG_CONTINUOUS = 2'd0;
  localparam logic [IDX_W-1:0] CFG_BUSY_THR   = 2'd1;
  localparam logic [IDX_W-1:0] CFG_OVR_THR    = 2'd2;

  // readout phases
  localparam logic [1:0] PH_WAIT  = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_RUN   = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  // event actions
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_ACCEPT = 2'd1;
  localparam logic [1:0] ACT_FLUSH  = 2'd2;
  localparam logic [1:0] ACT_REJECT = 2'd3;

  typedef struct packed {
    logic       continuous;
    logic [3:0] busy_thr;
    logic [3:0] ovr_thr;
  } cfg_t;

  typedef struct packed {
    logic strobe_low;
    logic regions_done;
    logic start_fifo_pop;
    logic end_fifo_pop;
  } in_t;

  typedef struct packed {
    logic              strobe_active;
    logic [1:0]        phase;
    logic [BUNCH_W-1:0] bunch;
    logic [EVC_W-1:0]  event_count;
    logic [FILL_W-1:0] start_fill;
    logic [FILL_W-1:0] end_fill;
    logic              violation;
    logic              flushed;
    logic              fifo_busy;
    logic              abort;
    logic              fatal;
    logic              buffers_busy;
    logic              busy;
    logic              ready;
    logic              start_pulse;
    logic [2:0]        pending;
    logic              done_all;
  } state_t;

  typedef struct packed {
    logic        frame_ready;
    logic        busy_res;
    logic        abort;
    logic        fatal;
    logic        region_start;
    logic        start_word_valid;
    logic [12:0] start_word;
    logic        violation_end_valid;
    logic        readout_end_valid;
    logic [2:0]  end_word;
    logic [1:0]  events_held;
    logic [1:0]  event_action;
  } res_t;

endpackage

// ===== design/frm_core.sv =====
// Configuration and state registers with the per-tick update logic.
module frm_core import frm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             accept,
  input  in_t              item,
  output res_t             res,
  output state_t           st
);

  cfg_t   cfg;
  state_t st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.continuous <= 1'b0;
      cfg.busy_thr   <= 4'd4;
      cfg.ovr_thr    <= 4'd6;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CONTINUOUS: cfg.continuous <= cfg_data[0];
        CFG_BUSY_THR:   cfg.busy_thr   <= cfg_data[3:0];
        CFG_OVR_THR:    cfg.ovr_thr    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  always_comb begin
    logic               start_push;
    logic               end_push_v;
    logic               end_push_r;
    logic               evc_full;
    logic [BUNCH_W:0]   bunch_inc;

    st_next    = st;
    res        = '0;
    start_push = 1'b0;
    end_push_v = 1'b0;
    end_push_r = 1'b0;
    evc_full   = int'(st.event_count) >= EVENT_BUFFERS;

    if (!item.strobe_low && !st.strobe_active) begin
      st_next.strobe_active = 1'b1;
      if (st.abort) begin
        res.event_action = ACT_REJECT;
      end else if (cfg.continuous) begin
        if (evc_full) begin
          res.event_action  = ACT_REJECT;
          st_next.violation = 1'b1;
          st_next.flushed   = 1'b0;
          st_next.ready     = 1'b0;
        end else if (int'(st.event_count) == EVENT_BUFFERS - 1) begin
          // drop the oldest frame, keep the count
          res.event_action  = ACT_FLUSH;
          st_next.violation = 1'b0;
          st_next.flushed   = 1'b1;
          st_next.ready     = 1'b1;
        end else begin
          st_next.event_count = st.event_count + 2'd1;
          res.event_action  = ACT_ACCEPT;
          st_next.violation = 1'b0;
          st_next.flushed   = 1'b0;
          st_next.ready     = 1'b1;
        end
      end else begin
        st_next.flushed = 1'b0;
        if (evc_full) begin
          res.event_action  = ACT_REJECT;
          st_next.ready     = 1'b0;
          st_next.violation = 1'b1;
        end else begin
          st_next.event_count = st.event_count + 2'd1;
          res.event_action  = ACT_ACCEPT;
          st_next.ready     = 1'b1;
          st_next.violation = 1'b0;
        end
      end
    end else if (item.strobe_low && st.strobe_active) begin
      st_next.ready         = 1'b0;
      st_next.strobe_active = 1'b0;
      res.start_word_valid  = 1'b1;
      res.start_word        = {st.violation, st.bunch};
      if (st.violation) begin
        end_push_v              = int'(st.end_fill) < FRAME_FIFO_DEPTH;
        res.violation_end_valid = 1'b1;
        st_next.violation       = 1'b0;
      end
      if (st.start_fill == '0 && st.end_fill == '0 && !end_push_v) begin
        st_next.fifo_busy = 1'b0;
        st_next.abort     = 1'b0;
      end else if (int'(st.start_fill) >= FRAME_FIFO_DEPTH) begin
        st_next.fifo_busy = 1'b1;
        st_next.abort     = 1'b1;
        st_next.fatal     = 1'b1;
      end else if (int'(st.start_fill) > int'(cfg.ovr_thr)) begin
        st_next.fifo_busy = 1'b1;
        st_next.abort     = 1'b1;
      end else if (int'(st.start_fill) > int'(cfg.busy_thr)) begin
        st_next.fifo_busy = 1'b1;
      end else if (!st.abort) begin
        st_next.fifo_busy = 1'b0;
      end
      start_push = int'(st.start_fill) < FRAME_FIFO_DEPTH;
    end

    // wrapping bunch counter
    bunch_inc = {1'b0, st.bunch} + {{BUNCH_W{1'b0}}, 1'b1};
    if (bunch_inc >= (BUNCH_W+1)'(ORBIT_LENGTH)) st_next.bunch = '0;
    else st_next.bunch = bunch_inc[BUNCH_W-1:0];

    unique case (st.phase)
      PH_WAIT: begin
        st_next.start_pulse = 1'b0;
        st_next.done_all    = 1'b0;
        if (st_next.event_count > 2'd1 ||
            (st_next.event_count == 2'd1 && !st_next.strobe_active))
          st_next.phase = PH_START;
      end
      PH_START: begin
        st_next.start_pulse = 1'b1;
        st_next.done_all    = 1'b0;
        st_next.phase       = PH_RUN;
      end
      PH_RUN: begin
        st_next.start_pulse = 1'b0;
        st_next.done_all    = item.regions_done && !st.start_pulse;
        if (st.done_all) begin
          st_next.pending = {st.flushed, 1'b0, st.busy};
          st_next.flushed = 1'b0;
          st_next.phase   = PH_DONE;
        end
      end
      PH_DONE: begin
        st_next.start_pulse = 1'b0;
        st_next.done_all    = 1'b0;
        end_push_r = int'(st.end_fill) + int'(end_push_v) < FRAME_FIFO_DEPTH;
        res.readout_end_valid = 1'b1;
        if (st_next.event_count != '0) st_next.event_count = st_next.event_count - 2'd1;
        st_next.phase = PH_WAIT;
      end
    endcase

    if (cfg.continuous) st_next.buffers_busy = st_next.event_count > 2'd1;
    else st_next.buffers_busy = int'(st_next.event_count) >= EVENT_BUFFERS;
    st_next.busy = st.fifo_busy || st.buffers_busy;

    // fill levels: pops never free room for this tick's pushes
    if (item.start_fifo_pop && st_next.start_fill != '0)
      st_next.start_fill = st_next.start_fill - FILL_W'(1);
    st_next.start_fill = st_next.start_fill + FILL_W'(start_push);
    if (item.end_fifo_pop && st_next.end_fill != '0)
      st_next.end_fill = st_next.end_fill - FILL_W'(1);
    st_next.end_fill = st_next.end_fill + FILL_W'(end_push_v) + FILL_W'(end_push_r);

    res.frame_ready  = st.ready;
    res.busy_res     = st_next.busy;
    res.abort        = st_next.abort;
    res.fatal        = st_next.fatal;
    res.region_start = st_next.start_pulse;
    res.events_held  = st_next.event_count;
    if (res.violation_end_valid || res.readout_end_valid) res.end_word = st.pending;
  end

endmodule

// ===== design/frm_out_reg.sv =====
// Result register between the update logic and the master-side stream.
module frm_out_reg import frm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  res_t        res,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata
);

  res_t res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_q <= res;
  end

  assign m_tdata = {4'b0000, res_q.event_action, res_q.events_held, res_q.end_word,
                    res_q.readout_end_valid, res_q.violation_end_valid,
                    res_q.start_word, res_q.start_word_valid, res_q.region_start,
                    res_q.fatal, res_q.abort, res_q.busy_res, res_q.frame_ready};

endmodule

// ===== design/frame_readout_manager.sv =====
// Top level of the frame readout manager: tick stream in, status stream out.
//
//  channel  | direction | width | contents
//  ---------+-----------+-------+----------------------------------------------
//  s_*      | in        | 8     | one clock tick of strobe, done and pop flags
//  m_*      | out       | 32    | registered flags, FIFO words, event action
//  cfg_*    | in        | 4     | mode and threshold registers, write only
//
// One transfer per cycle is sustained while m_tready is high or the result
// register is empty; the single result register sits after the update logic.
// A result is registered and appears on m_* in the cycle after its tick is taken.
// Input is held off only while the result register is full and m_tready is low.
// rst is synchronous and resets the state, m_tvalid and cfg to their defaults.
module frame_readout_manager import frm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // [0] strobe_low, [1] regions_done, [2] start_fifo_pop, [3] end_fifo_pop
  input  logic [7:0]       s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // [0] frame_ready, [1] busy_res, [2] abort, [3] fatal, [4] region_start,
  // [5] start_word_valid, [18:6] start_word, [19] violation_end_valid,
  // [20] readout_end_valid, [23:21] end_word, [25:24] events_held,
  // [27:26] event_action
  output logic [31:0]      m_tdata,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic   accept;
  in_t    item;
  res_t   res;
  state_t st;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign item.strobe_low     = s_tdata[0];
  assign item.regions_done   = s_tdata[1];
  assign item.start_fifo_pop = s_tdata[2];
  assign item.end_fifo_pop   = s_tdata[3];

  frm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .item      (item),
    .res       (res),
    .st        (st)
  );

  frm_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .res      (res),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // fatal stays set once reached
  a_fatal_sticky: assert property (@(posedge clk) disable iff (rst)
    st.fatal |=> st.fatal)
    else $error("fatal flag cleared");

  // fill levels stay within the FIFO depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    int'(st.start_fill) <= FRAME_FIFO_DEPTH && int'(st.end_fill) <= FRAME_FIFO_DEPTH)
    else $error("frame FIFO fill out of range");

  // a start word and a strobe-open action never share a result
  a_edge_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[5] |-> m_tdata[27:26] == ACT_NONE)
    else $error("start word and event action in one result");

  // a start pulse always coincides with the wait-for-regions phase
  a_pulse_phase: assert property (@(posedge clk) disable iff (rst)
    st.start_pulse |-> st.phase == PH_RUN)
    else $error("start pulse outside region readout");

endmodule
